// File: hdl/gsef_pkg.sv
`default_nettype none
package gsef_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// pixel and result fields
	localparam int PIX_W  = 24;
	localparam int GRAY_W = 8;
	localparam int EDGE_W = 8;
	localparam int SUM_W  = 10;
	localparam logic [EDGE_W-1:0] EDGE_MAX = 8'hff;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} item_ctl_t;

	function automatic logic [GRAY_W-1:0] gray_of(input logic [PIX_W-1:0] px);
		logic [GRAY_W-1:0] r4;
		logic [GRAY_W-1:0] g2;
		logic [GRAY_W-1:0] b4;
		r4 = {2'b00, px[7:2]};
		g2 = {1'b0, px[15:9]};
		b4 = {2'b00, px[23:18]};
		return r4 + g2 + b4;
	endfunction

endpackage
`default_nettype wire

// File: hdl/gsef_ram.sv
`default_nettype none
module gsef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/gsef_kernel.sv
`default_nettype none
module gsef_kernel #(
	parameter int COL_W = 10,
	parameter int ROW_W = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gsef_pkg::item_ctl_t               ctl_s1,
	input  logic [gsef_pkg::GRAY_W-1:0]       gray_s1,
	input  logic [gsef_pkg::GRAY_W-1:0]       top_s1,
	input  logic [gsef_pkg::GRAY_W-1:0]       mid_s1,
	input  logic [ROW_W-1:0]                  orow_s1,
	input  logic [COL_W-1:0]                  ocol_s1,
	output logic                              push,
	output logic [gsef_pkg::EDGE_W-1:0]       res_edge,
	output logic [ROW_W-1:0]                  res_row,
	output logic [COL_W-1:0]                  res_col,
	output logic                              res_last
);
	import gsef_pkg::*;

	// window: two columns back (l) and one column back (m)
	logic [GRAY_W-1:0] tl_q, ml_q, bl_q, tm_q, mm_q, bm_q;

	logic [SUM_W-1:0] right_sum, left_sum, bot_sum, top_sum;
	logic [SUM_W-1:0] right_s2, left_s2, bot_s2, top_s2;
	logic [SUM_W-1:0] gx_s3, gy_s3;
	logic [SUM_W:0]   mag;
	item_ctl_t        ctl_s2, ctl_s3;
	logic [ROW_W-1:0] row_s2, row_s3;
	logic [COL_W-1:0] col_s2, col_s3;

	function automatic logic [SUM_W-1:0] wsum(input logic [GRAY_W-1:0] a,
		input logic [GRAY_W-1:0] b, input logic [GRAY_W-1:0] c);
		return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
	endfunction

	assign right_sum = wsum(top_s1, mid_s1, gray_s1);
	assign left_sum  = wsum(tl_q, ml_q, bl_q);
	assign bot_sum   = wsum(bl_q, bm_q, gray_s1);
	assign top_sum   = wsum(tl_q, tm_q, top_s1);

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			tl_q <= tm_q;
			ml_q <= mm_q;
			bl_q <= bm_q;
			tm_q <= top_s1;
			mm_q <= mid_s1;
			bm_q <= gray_s1;
		end
		right_s2 <= right_sum;
		left_s2  <= left_sum;
		bot_s2   <= bot_sum;
		top_s2   <= top_sum;
		row_s2   <= orow_s1;
		col_s2   <= ocol_s1;
		gx_s3    <= (right_s2 >= left_s2) ? right_s2 - left_s2 : left_s2 - right_s2;
		gy_s3    <= (bot_s2 >= top_s2) ? bot_s2 - top_s2 : top_s2 - bot_s2;
		row_s3   <= row_s2;
		col_s3   <= col_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign mag      = {1'b0, gx_s3} + {1'b0, gy_s3};
	assign res_edge = (mag > (SUM_W+1)'(EDGE_MAX)) ? EDGE_MAX : mag[EDGE_W-1:0];
	assign res_row  = row_s3;
	assign res_col  = col_s3;
	assign res_last = ctl_s3.last;
	assign push     = ctl_s3.valid && ctl_s3.emit;

endmodule
`default_nettype wire

// File: hdl/gsef_out_fifo.sv
`default_nettype none
module gsef_out_fifo #(
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          tvalid,
	input  logic          tready,
	output logic [DW-1:0] tdata
);
	import gsef_pkg::*;

	logic [DW-1:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PEND_W-1:0]     count_q;
	logic                  pop;

	assign tvalid = (count_q != '0);
	assign tdata  = mem_q[rd_ptr_q];
	assign pop    = tvalid && tready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + PEND_W'(1);
				2'b01:   count_q <= count_q - PEND_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/gray_sobel_edge_filter.sv
// a result word passes the stage 1, s2 and s3 registers and the result queue before it shows on m_axis
// throughput: one pixel per clock; s_axis_tready drops only while 8 result words are owed
// the limit is the 8-deep result queue; a slot is reserved when an interior pixel is accepted
// reset: arst_n clears counters, pipeline valids and the queue; width/height return to 640/480
// line stores and window have no reset and need no clearing pass: a frame writes before it reads
`default_nettype none
module gray_sobel_edge_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int ROW_W  = $clog2(MAX_HEIGHT),
	localparam int OUT_BITS = 8 + ROW_W + COL_W,
	localparam int OUT_TW = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration writes
	input  logic                              wr_en,
	input  logic [gsef_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [gsef_pkg::CFG_DATA_W-1:0]   wr_data,
	// pixel stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gsef_pkg::PIX_W-1:0]        s_axis_tdata,  // pixel_word
	// edge stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [OUT_TW-1:0]                 m_axis_tdata,  // edge_value, out_row, out_col, zero fill
	output logic                              m_axis_tlast   // last_of_frame
);
	import gsef_pkg::*;

	localparam int DW = OUT_BITS + 1;

	// configuration registers
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	// raster position of the next pixel
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// result words reserved but not yet delivered
	logic [PEND_W-1:0] pend_q;

	logic [31:0]      w_ext, h_ext, last_col_full, last_row_full;
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;
	logic             s_acc, m_acc, col_end, row_end, emit0;

	// stage 1: line store read data lines up with these
	item_ctl_t         ctl_s1;
	logic [GRAY_W-1:0] gray_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [ROW_W-1:0]  orow_s1;
	logic [COL_W-1:0]  ocol_s1;
	logic [GRAY_W-1:0] top_rd, mid_rd;

	logic              push;
	logic [EDGE_W-1:0] res_edge;
	logic [ROW_W-1:0]  res_row;
	logic [COL_W-1:0]  res_col;
	logic              res_last;
	logic [DW-1:0]     q_data;

	// clamp the frame size to what the stores and counters hold
	assign w_ext = 32'(width_q);
	assign h_ext = 32'(height_q);
	assign last_col_full = (w_ext < 32'd3) ? 32'd2 :
		(w_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : w_ext - 32'd1;
	assign last_row_full = (h_ext < 32'd3) ? 32'd2 :
		(h_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : h_ext - 32'd1;
	assign last_col = last_col_full[COL_W-1:0];
	assign last_row = last_row_full[ROW_W-1:0];

	// a counter at or past the end wraps, also after a size change mid-frame
	assign col_end = (col_q >= last_col);
	assign row_end = (row_q >= last_row);
	assign emit0   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	assign s_axis_tready = (pend_q < PEND_W'(FIFO_DEPTH));
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= wr_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			ctl_s1 <= '0;
		end else begin
			if (s_acc) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			case ({s_acc && emit0, m_acc})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
			ctl_s1.valid <= s_acc;
			ctl_s1.emit  <= emit0;
			ctl_s1.last  <= row_end && col_end;
		end
	end

	always_ff @(posedge clk) begin
		gray_s1 <= gray_of(s_axis_tdata);
		addr_s1 <= col_q;
		orow_s1 <= row_q - ROW_W'(1);
		ocol_s1 <= col_q - COL_W'(1);
	end

	// line stores: read at the incoming column, written back in the cycle after;
	// the write column always trails the read column, so no forwarding is needed
	gsef_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_older_ram (
		.clk   (clk),
		.we    (ctl_s1.valid),
		.waddr (addr_s1),
		.wdata (mid_rd),
		.raddr (col_q),
		.rdata (top_rd)
	);

	gsef_ram #(.WIDTH(GRAY_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
		.clk   (clk),
		.we    (ctl_s1.valid),
		.waddr (addr_s1),
		.wdata (gray_s1),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// window shift, sobel sums and magnitude
	gsef_kernel #(.COL_W(COL_W), .ROW_W(ROW_W)) u_kernel (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.gray_s1  (gray_s1),
		.top_s1   (top_rd),
		.mid_s1   (mid_rd),
		.orow_s1  (orow_s1),
		.ocol_s1  (ocol_s1),
		.push     (push),
		.res_edge (res_edge),
		.res_row  (res_row),
		.res_col  (res_col),
		.res_last (res_last)
	);

	// result queue parts the pipeline from the consumer
	gsef_out_fifo #(.DW(DW)) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({res_last, res_col, res_row, res_edge}),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (q_data)
	);

	assign m_axis_tdata = OUT_TW'(q_data[DW-2:0]);
	assign m_axis_tlast = q_data[DW-1];

endmodule
`default_nettype wire

// File: hdl/gsef_checker.sv
`default_nettype none
module gsef_checker #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W  = $clog2(MAX_WIDTH),
	localparam int ROW_W  = $clog2(MAX_HEIGHT),
	localparam int OUT_TW = ((8 + ROW_W + COL_W + 7) / 8) * 8
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [OUT_TW-1:0] m_axis_tdata,
	input wire logic              m_axis_tlast
);

	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] cur_col;
	logic [COL_W-1:0] prev_col_q;
	logic             have_q;
	logic             m_acc;

	assign cur_row = m_axis_tdata[8+ROW_W-1:8];
	assign cur_col = m_axis_tdata[8+ROW_W+COL_W-1:8+ROW_W];
	assign m_acc   = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			prev_col_q <= '0;
		end else if (m_acc) begin
			have_q     <= 1'b1;
			prev_col_q <= cur_col;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result word changed");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cur_row != '0) && (cur_col != '0))
		else $error("border pixel emitted");

	a_col_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && have_q |-> (cur_col == prev_col_q + COL_W'(1)) || (cur_col == COL_W'(1)))
		else $error("output columns out of order");

endmodule

bind gray_sobel_edge_filter gsef_checker #(
	.MAX_WIDTH  (MAX_WIDTH),
	.MAX_HEIGHT (MAX_HEIGHT)
) u_gsef_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: test/gray_sobel_edge_filter_tb.sv
`default_nettype none
module gray_sobel_edge_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gsef_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int LINE_MAX       = 1024;   // widest row the block handles
	localparam int ROWS_MAX       = 4096;   // tallest frame the block handles
	localparam int SETTLE_CYCLES  = 12;     // slack for the result pipeline to flush
	localparam int WATCHDOG_LIMIT = 2000;   // cycles without any accepted word
	localparam int HOLD_AFTER     = 40;     // edge words predicted before the long hold
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PIXELS  = 180;

	// small frame with flat, saturating and single-channel patches
	localparam logic [PIX_W-1:0] DIRECTED_FRAME [25] = '{
		24'h000000, 24'hffffff, 24'h000000, 24'hffffff, 24'h000000,
		24'hffffff, 24'hffffff, 24'h000000, 24'h000000, 24'h0000ff,
		24'h404040, 24'h404040, 24'h404040, 24'h00ff00, 24'hff0000,
		24'h404040, 24'h404040, 24'h404040, 24'h010101, 24'hffffff,
		24'h404040, 24'h404040, 24'h404040, 24'h030303, 24'hffffff
	};

	typedef struct {
		logic [EDGE_W-1:0] edge_value;
		logic [11:0]       row;
		logic [9:0]        col;
		logic              last;
	} edge_word_t;

	// ports; the inputs are known from time zero
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  wr_en         = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index      = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] wr_data       = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = '0;  // pixel_word
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;        // edge_value, out_row, out_col, zero fill
	logic                  m_axis_tlast;        // last_of_frame

	// shadow of the block: size registers, counters, line stores, window
	int unsigned     cfg_width  = WIDTH_RESET;
	int unsigned     cfg_height = HEIGHT_RESET;
	int unsigned     row_pos    = 0;
	int unsigned     col_pos    = 0;
	logic [GRAY_W-1:0] older_line [LINE_MAX] = '{default: '0};
	logic [GRAY_W-1:0] newer_line [LINE_MAX] = '{default: '0};
	logic [GRAY_W-1:0] win_far  [3] = '{default: '0};  // two columns back: top, mid, bottom
	logic [GRAY_W-1:0] win_near [3] = '{default: '0};  // one column back

	logic [PIX_W-1:0] pixel_feed [$];     // pixels waiting for the driver
	edge_word_t       pending_edges [$];  // edge words owed by the block

	int unsigned edges_predicted = 0;
	int unsigned edges_checked   = 0;
	int unsigned pixels_sent     = 0;
	int unsigned mismatch_count  = 0;
	int unsigned random_pixels   = 0;
	int unsigned idle_cycles     = 0;

	bit src_gaps_on  = 1'b0;
	bit sink_gaps_on = 1'b0;
	int gap_left     = 0;
	int stall_left   = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;

	gray_sobel_edge_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// sizes in use, registers clamped to what the block supports
	function automatic int unsigned eff_width();
		if (cfg_width < 3) return 3;
		if (cfg_width > LINE_MAX) return LINE_MAX;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		if (cfg_height < 3) return 3;
		if (cfg_height > ROWS_MAX) return ROWS_MAX;
		return cfg_height;
	endfunction

	// pixels still needed to close the frame from the current position
	function automatic int unsigned frame_remaining();
		int unsigned w;
		int unsigned h;
		int unsigned row_left;
		w = eff_width();
		h = eff_height();
		// a column already past a shrunk width wraps on the next pixel
		row_left = (col_pos >= w) ? 1 : w - col_pos;
		if (row_pos + 1 >= h) return row_left;
		return row_left + (h - row_pos - 1) * w;
	endfunction

	function automatic int unsigned abs_delta(input int unsigned a, input int unsigned b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// advance the shadow by one accepted pixel, queue the edge word it completes
	function automatic void sobel_step(input logic [PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int unsigned idx;
		int unsigned gray;
		int unsigned top;
		int unsigned mid;
		int unsigned gx;
		int unsigned gy;
		int unsigned mag;
		edge_word_t  word;
		w = eff_width();
		h = eff_height();
		c = col_pos;
		r = row_pos;
		// quarter red, half green, quarter blue, each truncated
		gray = px[7:0] / 4 + px[15:8] / 2 + px[23:16] / 4;
		idx = (c < LINE_MAX) ? c : LINE_MAX - 1;
		top = older_line[idx];
		mid = newer_line[idx];
		// interior only: the window centre is one row up, one column left
		if (r >= 2 && c >= 2) begin
			gx = abs_delta(top + 2 * mid + gray,
				win_far[0] + 2 * win_far[1] + win_far[2]);
			gy = abs_delta(win_far[2] + 2 * win_near[2] + gray,
				win_far[0] + 2 * win_near[0] + top);
			mag = gx + gy;
			word.edge_value = (mag > EDGE_MAX) ? EDGE_MAX : EDGE_W'(mag);
			word.row = 12'(r - 1);
			word.col = 10'(c - 1);
			word.last = (r + 1 >= h) && (c + 1 >= w);
			pending_edges.push_back(word);
			edges_predicted++;
		end
		win_far = win_near;
		win_near[0] = GRAY_W'(top);
		win_near[1] = GRAY_W'(mid);
		win_near[2] = GRAY_W'(gray);
		older_line[idx] = GRAY_W'(mid);
		newer_line[idx] = GRAY_W'(gray);
		// counters wrap at or past the last position, also after a size change
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("error at %0t: %s", $realtime, msg);
	endfunction

	// compare one edge word against the oldest owed one
	function automatic void check_edge_word(input logic [31:0] data, input logic last);
		edge_word_t want;
		if (pending_edges.size() == 0) begin
			note_failure($sformatf("edge word %h last %b with nothing owed", data, last));
			return;
		end
		want = pending_edges.pop_front();
		edges_checked++;
		if (data[7:0] !== want.edge_value || data[19:8] !== want.row
				|| data[29:20] !== want.col || last !== want.last)
			note_failure($sformatf(
				"expected value %0d row %0d col %0d last %b, got value %0d row %0d col %0d last %b",
				want.edge_value, want.row, want.col, want.last,
				data[7:0], data[19:8], data[29:20], last));
	endfunction

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random colors mixed with flat gray patches and the extremes
	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
			1: return 24'h606060 + PIX_W'($urandom_range(0, 3));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// pixel driver: presents the next queued pixel after a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				sobel_step(s_axis_tdata);
				pixels_sent++;
			end
			// a word not yet taken stays on the bus
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_feed.size() > 0) begin
					s_axis_tdata <= pixel_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left <= src_gaps_on ? pick_gap() : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// edge monitor and sink: random stalls plus one long hold that backs up the pixel side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) check_edge_word(m_axis_tdata, m_axis_tlast);
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && edges_predicted >= HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left <= (sink_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a word, %0d edge words still owed",
					idle_cycles, pending_edges.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// block idle: nothing queued, nothing on the bus, nothing owed, pipeline flushed
	task automatic wait_drained();
		while (pixel_feed.size() != 0 || s_axis_tvalid || pending_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both size registers back to back, only while idle
	task automatic set_size(input int unsigned width_reg, input int unsigned height_reg);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_IMAGE_WIDTH;
		wr_data <= CFG_DATA_W'(width_reg);
		@(posedge clk);
		wr_index <= REG_IMAGE_HEIGHT;
		wr_data <= CFG_DATA_W'(height_reg);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_width = width_reg & 32'h7ff;
		cfg_height = height_reg & 32'h1fff;
	endtask

	task automatic set_idling(input bit src_on, input bit sink_on);
		src_gaps_on <= src_on;
		sink_gaps_on <= sink_on;
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) pixel_feed.push_back(random_pixel());
	endtask

	initial begin
		int unsigned part;
		int unsigned total;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed 5x5 frame: saturation, flat zero-gradient patch, channel extremes
		set_size(5, 5);
		set_idling(1'b0, 1'b0);
		foreach (DIRECTED_FRAME[i]) pixel_feed.push_back(DIRECTED_FRAME[i]);
		wait_drained();

		// size change in mid-frame: width shrinks, height drops to the current row
		set_size(7, 6);
		set_idling(1'b1, 1'b1);
		send_random(25);
		wait_drained();
		set_size(5, 4);
		send_random(frame_remaining() + 20);
		wait_drained();

		// no gaps so the long hold backs up the pixel side
		set_size(16, 6);
		set_idling(1'b0, 1'b0);
		send_random(frame_remaining());
		wait_drained();

		// registers above range clamp to the maximum, then a shrink past the column wraps
		set_size(2047, 8191);
		set_idling(1'b1, 1'b1);
		send_random(30);
		wait_drained();
		set_size(5, 2);
		send_random(frame_remaining());
		wait_drained();

		// registers below range clamp to 3
		set_size(2, 0);
		set_idling(1'b1, 1'b0);
		send_random(frame_remaining());
		wait_drained();

		// random small frames, some with a size change part way through
		while (random_pixels < RANDOM_PIXELS) begin
			set_size(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9));
			if ($urandom_range(0, 3) == 0)
				set_idling(1'b0, 1'b0);
			else
				set_idling(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0) begin
				// stop inside the frame, shrink or keep the width, any height
				part = $urandom_range(1, frame_remaining() - 1);
				send_random(part);
				wait_drained();
				set_size($urandom_range(0, eff_width()), $urandom_range(0, 12));
				total = part + frame_remaining();
				send_random(frame_remaining());
			end else begin
				total = frame_remaining() * $urandom_range(1, 2);
				send_random(total);
			end
			random_pixels += total;
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d pixels: small frames, sizes clamped from above and below,",
			pixels_sent);
		$display("size changes inside a frame and a long output hold; %0d edge words checked",
			edges_checked);
		if (mismatch_count == 0 && pending_edges.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d edge words never seen",
				mismatch_count, pending_edges.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
`default_nettype wire
